/* src/lpfd_pkg.sv */
// lpfd_pkg: shared constants and types for the length-prefixed frame decoder
// no dependencies; used by the channel interfaces, lpfd_core and the top level
package lpfd_pkg;

	localparam int HEADER_BYTES = 8;
	localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
	localparam int HDR_STORE_W  = (HEADER_BYTES - 1) * 8;
	localparam int LEN_W        = 24;

	localparam logic [HDR_CNT_W-1:0] HDR_CNT_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 24'd65528;
	localparam logic [2:0]       OPCODE_MAX        = 3'd4;

	// input op codes
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_CORRUPT = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [2:0]       opcode;
		logic [LEN_W-1:0] payload_length;
		logic [7:0]       payload_byte;
		logic             last;
	} lpfd_result_t;

endpackage

/* src/lpfd_ifs.sv */
// lpfd channel interfaces: byte input, result output and config write channel
// depends on lpfd_pkg
interface lpfd_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, op, data_byte, input ready);
	modport sink   (input valid, op, data_byte, output ready);
endinterface

interface lpfd_out_if import lpfd_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [2:0]       opcode;
	logic [LEN_W-1:0] payload_length;
	logic [7:0]       payload_byte;
	logic             last;

	modport source (output valid, kind, opcode, payload_length, payload_byte, last,
		input ready);
	modport sink   (input valid, kind, opcode, payload_length, payload_byte, last,
		output ready);
endinterface

interface lpfd_cfg_if import lpfd_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* src/lpfd_core.sv */
// lpfd_core: frame parsing state and the per-beat decode logic
// depends on lpfd_pkg
module lpfd_core import lpfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             op,
	input  logic [7:0]       data_byte,
	input  logic [LEN_W-1:0] max_payload,
	output logic             res_valid,
	output lpfd_result_t     res
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [HDR_CNT_W-1:0]   hdr_cnt_q, hdr_cnt_n;
	logic [HDR_STORE_W-1:0] hdr_q, hdr_n;
	logic [LEN_W-1:0]       remain_q, remain_n;
	logic [2:0]             frame_opc_q, frame_opc_n;

	logic [31:0] hdr_opc;
	logic [31:0] hdr_len;
	logic        hdr_bad;

	// the last header byte completes the length word
	assign hdr_opc = hdr_q[31:0];
	assign hdr_len = {data_byte, hdr_q[HDR_STORE_W-1:32]};
	assign hdr_bad = (|hdr_opc[31:3]) || (hdr_opc[2:0] > OPCODE_MAX)
		|| (|hdr_len[31:LEN_W]) || (hdr_len[LEN_W-1:0] > max_payload);

	always_comb begin
		phase_n     = phase_q;
		hdr_cnt_n   = hdr_cnt_q;
		hdr_n       = hdr_q;
		remain_n    = remain_q;
		frame_opc_n = frame_opc_q;
		res_valid   = 1'b0;
		res         = '0;
		if (op == OP_CLEAR) begin
			phase_n   = PH_HEADER;
			hdr_cnt_n = '0;
			remain_n  = '0;
		end else begin
			unique case (phase_q)
				PH_ERROR: begin
				end
				PH_PAYLOAD: begin
					res_valid        = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.opcode       = frame_opc_q;
					res.payload_byte = data_byte;
					res.last         = (remain_q <= LEN_W'(1));
					if (res.last) begin
						phase_n   = PH_HEADER;
						hdr_cnt_n = '0;
						remain_n  = '0;
					end else begin
						remain_n = remain_q - LEN_W'(1);
					end
				end
				default: begin
					phase_n = PH_HEADER;
					if (hdr_cnt_q != HDR_CNT_LAST) begin
						hdr_n     = {data_byte, hdr_q[HDR_STORE_W-1:8]};
						hdr_cnt_n = hdr_cnt_q + HDR_CNT_W'(1);
					end else begin
						hdr_cnt_n = '0;
						res_valid = 1'b1;
						res.last  = 1'b1;
						if (hdr_bad) begin
							phase_n  = PH_ERROR;
							remain_n = '0;
							res.kind = KIND_CORRUPT;
						end else begin
							frame_opc_n        = hdr_opc[2:0];
							res.kind           = KIND_HEADER;
							res.opcode         = hdr_opc[2:0];
							res.payload_length = hdr_len[LEN_W-1:0];
							remain_n           = hdr_len[LEN_W-1:0];
							if (hdr_len[LEN_W-1:0] != '0) begin
								phase_n  = PH_PAYLOAD;
								res.last = 1'b0;
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= '0;
			hdr_q       <= '0;
			remain_q    <= '0;
			frame_opc_q <= '0;
		end else if (en) begin
			phase_q     <= phase_n;
			hdr_cnt_q   <= hdr_cnt_n;
			hdr_q       <= hdr_n;
			remain_q    <= remain_n;
			frame_opc_q <= frame_opc_n;
		end
	end

endmodule

/* src/length_prefixed_frame_decoder.sv */
// length_prefixed_frame_decoder: top level, input and result registers around lpfd_core
// depends on lpfd_pkg, lpfd_ifs (channel interfaces) and lpfd_core
//
// channel  dir  beat contents                                   accepted when
// rx       in   op, data_byte                                   rx.valid & rx.ready
// tx       out  kind, opcode, payload_length, payload_byte, last tx.valid & tx.ready
// cfg      in   data (max_payload, 24 bits)                     cfg.valid & cfg.ready
//
// one rx beat per cycle sustained while tx.ready stays high; the result of a beat passes
// through the input register, then decode into the result register, before it is on tx,
// and a stalled tx can hold it in either register
// rate is set by the single decode pass in lpfd_core: header shift, length compare,
// payload countdown are all combinational
// a stalled tx holds its result; rx keeps taking beats until the input register
// is also full, so ready on rx follows tx.ready combinationally
// arst_n clears the stage valids, parser state and restores max_payload to 65528
module length_prefixed_frame_decoder import lpfd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	lpfd_in_if.sink    rx,
	lpfd_out_if.source tx,
	lpfd_cfg_if.sink   cfg
);

	// input register stage
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// result register stage
	logic         valid_s2;
	lpfd_result_t res_s2;

	logic [LEN_W-1:0] max_payload_q;

	logic         advance;
	logic         core_valid;
	lpfd_result_t core_res;

	// the s1 beat moves on whenever the result register has room for its result
	assign advance  = valid_s1 && (!valid_s2 || tx.ready);
	assign rx.ready = !valid_s1 || advance;

	// config must be written only while idle (unchecked), so a plain register is enough
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg.valid) begin
			max_payload_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// payload of the input stage needs no reset
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			op_s1   <= rx.op;
			byte_s1 <= rx.data_byte;
		end
	end

	lpfd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.op          (op_s1),
		.data_byte   (byte_s1),
		.max_payload (max_payload_q),
		.res_valid   (core_valid),
		.res         (core_res)
	);

	// beats that give no result (header bytes, discards, clear) just drain s2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= core_valid;
		end else if (tx.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			res_s2 <= core_res;
		end
	end

	assign tx.valid          = valid_s2;
	assign tx.kind           = res_s2.kind;
	assign tx.opcode         = res_s2.opcode;
	assign tx.payload_length = res_s2.payload_length;
	assign tx.payload_byte   = res_s2.payload_byte;
	assign tx.last           = res_s2.last;

	// a header result closes the frame exactly when its length is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.kind == KIND_HEADER |-> tx.last == (tx.payload_length == '0))
		else $error("header result last flag disagrees with length");

	// a corrupt result always ends the frame and carries no opcode
	assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.kind == KIND_CORRUPT |-> tx.last && tx.opcode == '0)
		else $error("corrupt result malformed");

	// a held input beat is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(byte_s1))
		else $error("input stage overwritten while stalled");

	// a clear beat never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_CLEAR |-> !core_valid)
		else $error("clear beat produced a result");

endmodule

/* dv/length_prefixed_frame_decoder_tb.sv */
// length_prefixed_frame_decoder_tb: self-checking bench that streams frames through the decoder
// and checks every result beat against its own model; depends on lpfd_pkg, lpfd_ifs and the
// length_prefixed_frame_decoder top level
`timescale 1ns / 1ps

module length_prefixed_frame_decoder_tb;
	import lpfd_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	// input register plus result register, with some slack
	localparam int DRAIN_CYCLES = 4;

	typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_ERROR} frame_phase_t;

	logic clk = 1'b0;
	logic arst_n;

	lpfd_in_if  rx_if ();
	lpfd_out_if tx_if ();
	lpfd_cfg_if cfg_if ();

	length_prefixed_frame_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// decoder model state, matches the block right after reset
	frame_phase_t     frame_phase = PH_HEADER;
	logic [2:0]       hdr_count   = '0;
	logic [63:0]      hdr_shift   = '0;
	logic [LEN_W-1:0] bytes_left  = '0;
	logic [2:0]       frame_op    = '0;
	logic [LEN_W-1:0] max_len     = MAX_PAYLOAD_RESET;

	lpfd_result_t due_results[$];

	int error_count  = 0;
	int beats_sent   = 0;
	int cycle_count  = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;

	// back to an empty header, dropping any partial frame
	function automatic void restart_header();
		frame_phase = PH_HEADER;
		hdr_count   = '0;
		hdr_shift   = '0;
		bytes_left  = '0;
	endfunction

	// advance the model by one rx beat; returns 1 when the beat yields a result
	function automatic bit decode_beat(input logic op, input logic [7:0] b,
		output lpfd_result_t res);
		logic [31:0] hdr_op;
		logic [31:0] hdr_len;
		res = '0;
		if (op == OP_CLEAR) begin
			restart_header();
			return 1'b0;
		end
		// after a corrupt header everything is dropped until a clear
		if (frame_phase == PH_ERROR)
			return 1'b0;
		if (frame_phase == PH_PAYLOAD) begin
			res.kind         = KIND_PAYLOAD;
			res.opcode       = frame_op;
			res.payload_byte = b;
			res.last         = (bytes_left <= 1);
			if (res.last)
				restart_header();
			else
				bytes_left = bytes_left - 1'b1;
			return 1'b1;
		end
		// header bytes arrive lsb first, so shift in from the top
		hdr_shift = {b, hdr_shift[63:8]};
		if (hdr_count != HDR_CNT_LAST) begin
			hdr_count = hdr_count + 1'b1;
			return 1'b0;
		end
		hdr_count = '0;
		hdr_op    = hdr_shift[31:0];
		hdr_len   = hdr_shift[63:32];
		hdr_shift = '0;
		// a length wider than 24 bits always fails the compare
		if (hdr_op > 32'(OPCODE_MAX) || hdr_len > {8'h00, max_len}) begin
			frame_phase = PH_ERROR;
			bytes_left  = '0;
			res.kind    = KIND_CORRUPT;
			res.last    = 1'b1;
			return 1'b1;
		end
		frame_op   = hdr_op[2:0];
		res.kind   = KIND_HEADER;
		res.opcode = frame_op;
		if (hdr_len == 0) begin
			// empty frame: the header is the whole frame
			frame_phase = PH_HEADER;
			bytes_left  = '0;
			res.last    = 1'b1;
		end else begin
			frame_phase        = PH_PAYLOAD;
			bytes_left         = hdr_len[LEN_W-1:0];
			res.payload_length = hdr_len[LEN_W-1:0];
		end
		return 1'b1;
	endfunction

	// sample every handshake at the rising edge: config, rx beats feed the model, tx beats get checked
	always @(posedge clk) begin : monitor
		lpfd_result_t predicted;
		lpfd_result_t got;
		lpfd_result_t want;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				max_len = cfg_if.data;
			if (rx_if.valid && rx_if.ready) begin
				if (decode_beat(rx_if.op, rx_if.data_byte, predicted))
					due_results.insert(due_results.size(), predicted);
			end
			if (tx_if.valid && tx_if.ready) begin
				got.kind           = tx_if.kind;
				got.opcode         = tx_if.opcode;
				got.payload_length = tx_if.payload_length;
				got.payload_byte   = tx_if.payload_byte;
				got.last           = tx_if.last;
				if (due_results.size() == 0) begin
					$error("result beat with nothing pending: kind %0d opcode %0d",
						got.kind, got.opcode);
					error_count++;
				end else begin
					want = due_results.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, got.kind);
						error_count++;
					end
					if (got.opcode !== want.opcode) begin
						$error("opcode: expected %0d, actual %0d", want.opcode, got.opcode);
						error_count++;
					end
					if (got.payload_length !== want.payload_length) begin
						$error("payload_length: expected %0d, actual %0d",
							want.payload_length, got.payload_length);
						error_count++;
					end
					if (got.payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected 0x%02h, actual 0x%02h",
							want.payload_byte, got.payload_byte);
						error_count++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, got.last);
						error_count++;
					end
				end
			end
		end
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("length_prefixed_frame_decoder: mismatch");
			$finish;
		end
	end

	// result side back-pressure, one draw per cycle
	always @(negedge clk)
		tx_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

	// one rx beat; entered and left on a falling edge, valid may stay high into the next beat
	task automatic send_beat(input logic op, input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rx_if.valid     <= 1'b0;
			rx_if.op        <= 1'($urandom_range(0, 1));
			rx_if.data_byte <= 8'($urandom_range(0, 255));
			@(negedge clk);
		end
		rx_if.valid     <= 1'b1;
		rx_if.op        <= op;
		rx_if.data_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_clear();
		send_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
	endtask

	// little-endian opcode word, then little-endian length word
	task automatic send_header(input logic [31:0] opc, input logic [31:0] len);
		for (int i = 0; i < 4; i++)
			send_beat(OP_BYTE, opc[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			send_beat(OP_BYTE, len[8*i +: 8]);
	endtask

	task automatic send_stream_bytes(input int n);
		repeat (n)
			send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
	endtask

	// hold rx off until every pending result beat has come out
	task automatic drain_results();
		rx_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (due_results.size() != 0);
	endtask

	// fully idle: results drained and the pipeline empty of header bytes too
	task automatic settle_block();
		drain_results();
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_max_payload(input logic [LEN_W-1:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// basic shapes under the reset limit: short frame, all-ones header, empty frame
	task automatic test_directed();
		send_header(32'd4, 32'd1);
		send_beat(OP_BYTE, 8'hFF);
		// all-ones header: bad opcode and oversize length, then a dropped byte
		send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(OP_BYTE, 8'h00);
		send_clear();
		send_header(32'd0, 32'd0);
	endtask

	// both ends of the length limit
	task automatic test_length_limits();
		settle_block();
		write_max_payload('0);
		// zero limit: only empty frames pass
		send_header(32'd2, 32'd0);
		send_header(32'd1, 32'd1);
		send_clear();
		settle_block();
		write_max_payload('1);
		// widest legal length, cut off by a clear mid payload
		send_header(32'd3, 32'h00FF_FFFF);
		send_stream_bytes(2);
		send_clear();
		// one past 24 bits never fits
		send_header(32'd0, 32'h0100_0000);
		send_clear();
		// clear in the middle of a header
		send_stream_bytes(3);
		send_clear();
	endtask

	// mostly well-formed frames with random content, plus broken ones and noise
	task automatic test_random_frames(input int n_beats, input logic [LEN_W-1:0] limit);
		int unsigned pick;
		int unsigned len;
		int unsigned cap;
		int          first_beat;
		settle_block();
		write_max_payload(limit);
		cap        = (limit < 16) ? limit : 16;
		first_beat = beats_sent;
		while (beats_sent - first_beat < n_beats) begin
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				len = $urandom_range(0, cap);
				send_header($urandom_range(0, int'(OPCODE_MAX)), len);
				if (len > 1 && $urandom_range(0, 9) == 0) begin
					// frame dropped part way through its payload
					send_stream_bytes($urandom_range(1, len - 1));
					send_clear();
				end else begin
					send_stream_bytes(len);
				end
			end else if (pick < 78) begin
				// opcode out of range, small values alias into 3 bits
				if ($urandom_range(0, 1))
					send_header($urandom_range(int'(OPCODE_MAX) + 1, 7), $urandom_range(0, cap));
				else
					send_header($urandom_range(8, 32'hFFFF_FFFF), $urandom_range(0, cap));
				send_stream_bytes($urandom_range(0, 4));
				send_clear();
			end else if (pick < 88) begin
				// length just over the limit or beyond 24 bits
				if (limit == '1 || $urandom_range(0, 1))
					len = $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
				else
					len = limit + $urandom_range(1, 16);
				send_header($urandom_range(0, int'(OPCODE_MAX)), len);
				send_stream_bytes($urandom_range(0, 4));
				send_clear();
			end else if (pick < 94) begin
				// partial header thrown away
				send_stream_bytes($urandom_range(1, HEADER_BYTES - 1));
				send_clear();
			end else begin
				// raw noise, then resync
				send_stream_bytes($urandom_range(1, 12));
				send_clear();
			end
			if ($urandom_range(0, 19) == 0)
				drain_results();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		rx_if.valid     = 1'b0;
		rx_if.op        = OP_BYTE;
		rx_if.data_byte = '0;
		tx_if.ready     = 1'b0;
		cfg_if.valid    = 1'b0;
		cfg_if.data     = '0;
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender gaps light, receiver mostly stalled
		src_idle_pct = 35;
		snk_idle_pct = 82;
		test_directed();
		test_length_limits();
		test_random_frames(150, 24'd8);

		// sender mostly idle, receiver mostly ready
		src_idle_pct = 82;
		snk_idle_pct = 35;
		test_random_frames(150, '1);

		// full rate both ways, tiny limit so corrupt headers are common
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_frames(150, 24'd3);

		settle_block();
		if (error_count == 0)
			$display("length_prefixed_frame_decoder: match");
		else
			$display("length_prefixed_frame_decoder: mismatch");
		$finish;
	end

endmodule

/* files.f */
src/lpfd_pkg.sv
src/lpfd_ifs.sv
src/lpfd_core.sv
src/length_prefixed_frame_decoder.sv
dv/length_prefixed_frame_decoder_tb.sv
